@@ rtl/adbd_pkg.sv @@
// ----------------------------------------------------------------------------
// ADPCM block decoder package
// Shared types, constants and the filter coefficient table.
// ----------------------------------------------------------------------------
package adbd_pkg;

  localparam int BYTE_W   = 8;
  localparam int SAMPLE_W = 16;
  localparam int POS_W    = 4;
  localparam int SHIFT_W  = 5;
  localparam int FILT_W   = 4;
  localparam int COEF_W   = 8;

  localparam logic [POS_W-1:0] POS_HEADER = 4'd0;
  localparam logic [POS_W-1:0] POS_FLAGS  = 4'd1;
  localparam logic [POS_W-1:0] POS_LAST   = 4'd15;

  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd16;

  localparam logic signed [31:0] SAMPLE_MIN = -32'sd32768;
  localparam logic signed [31:0] SAMPLE_MAX = 32'sd32767;
  localparam logic signed [24:0] ROUND_BIAS = 25'sd32;

  typedef struct packed {
    logic signed [COEF_W-1:0] c1;
    logic signed [COEF_W-1:0] c2;
  } coef_pair_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take_byte;
    logic take_header;
    logic emit;
    logic phase_hi;
    logic block_end;
  } adbd_cmd_t;

  function automatic coef_pair_t coef_lookup(input logic [FILT_W-1:0] id);
    coef_pair_t c;
    case (id)
      4'd1:    c = '{c1: 8'sd60,  c2: 8'sd0};
      4'd2:    c = '{c1: 8'sd115, c2: -8'sd52};
      4'd3:    c = '{c1: 8'sd98,  c2: -8'sd55};
      4'd4:    c = '{c1: 8'sd122, c2: -8'sd60};
      default: c = '{c1: 8'sd0,   c2: 8'sd0};
    endcase
    return c;
  endfunction

endpackage

@@ rtl/adpcm_block_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// ADPCM block decoder
// Decodes a byte stream of 16-byte ADPCM sound blocks into 16-bit samples.
// ----------------------------------------------------------------------------
// Header and flag bytes are taken without giving a beat. Each data byte
// gives two sample beats, low nibble first, because one shared prediction
// unit computes one sample per cycle when the output is not stalled, and
// the second sample depends on the first. The next byte is accepted in the
// cycle of the second sample. The last sample of a block carries block_end.
module adpcm_block_decoder_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [adbd_pkg::BYTE_W-1:0]           byte_in,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [adbd_pkg::SAMPLE_W-1:0]  sample,
  output logic                                  pair_last,
  output logic                                  block_end
);

  adbd_pkg::adbd_cmd_t cmd;

  adbd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  adbd_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .byte_in   (byte_in),
    .cmd       (cmd),
    .sample    (sample),
    .pair_last (pair_last),
    .block_end (block_end)
  );

endmodule

@@ rtl/adbd_ctrl.sv @@
// ----------------------------------------------------------------------------
// ADPCM block decoder controller
// Tracks the byte position and sequences the two samples of a data byte.
// ----------------------------------------------------------------------------
module adbd_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  output adbd_pkg::adbd_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LO   = 2'd1;
  localparam logic [1:0] ST_HI   = 2'd2;

  logic [1:0]                 state;
  logic [1:0]                 state_next;
  logic [adbd_pkg::POS_W-1:0] pos;
  logic                       last_byte;
  logic                       out_free;
  logic                       accept;
  logic                       is_data;
  logic                       emit;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = !((state == ST_IDLE) || ((state == ST_HI) && out_free));
  assign accept   = in_valid && !in_stall;
  assign is_data  = (pos != adbd_pkg::POS_HEADER) && (pos != adbd_pkg::POS_FLAGS);
  assign emit     = ((state == ST_LO) || (state == ST_HI)) && out_free;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && is_data) state_next = ST_LO;
      end
      ST_LO: begin
        if (out_free) state_next = ST_HI;
      end
      ST_HI: begin
        if (out_free) state_next = (accept && is_data) ? ST_LO : ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pos       <= adbd_pkg::POS_HEADER;
      last_byte <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        pos       <= pos + 4'd1;
        last_byte <= (pos == adbd_pkg::POS_LAST);
      end
      if (emit) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_comb begin
    cmd.take_byte   = accept && is_data;
    cmd.take_header = accept && (pos == adbd_pkg::POS_HEADER);
    cmd.emit        = emit;
    cmd.phase_hi    = (state == ST_HI);
    cmd.block_end   = last_byte && (state == ST_HI);
  end

endmodule

@@ rtl/adbd_dp.sv @@
// ----------------------------------------------------------------------------
// ADPCM block decoder datapath
// Header registers, sample history, one shared sample unit and output register.
// ----------------------------------------------------------------------------
module adbd_dp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic [adbd_pkg::BYTE_W-1:0]           byte_in,
  input  adbd_pkg::adbd_cmd_t                   cmd,
  output logic signed [adbd_pkg::SAMPLE_W-1:0]  sample,
  output logic                                  pair_last,
  output logic                                  block_end
);

  logic [adbd_pkg::BYTE_W-1:0]          data_byte;
  logic [adbd_pkg::SHIFT_W-1:0]         shift_amount;
  logic [adbd_pkg::FILT_W-1:0]          filter_id;
  logic signed [adbd_pkg::SAMPLE_W-1:0] previous_one;
  logic signed [adbd_pkg::SAMPLE_W-1:0] previous_two;

  adbd_pkg::coef_pair_t                 coef;
  logic [3:0]                           nib;
  logic signed [31:0]                   placed;
  logic signed [31:0]                   scaled;
  logic signed [23:0]                   prod1;
  logic signed [23:0]                   prod2;
  logic signed [24:0]                   pred;
  logic signed [24:0]                   pred_sh;
  logic signed [31:0]                   sum;
  logic signed [adbd_pkg::SAMPLE_W-1:0] decoded;

  always_comb begin
    coef    = adbd_pkg::coef_lookup(filter_id);
    nib     = cmd.phase_hi ? data_byte[7:4] : data_byte[3:0];
    placed  = $signed({nib, 28'd0});
    scaled  = placed >>> shift_amount;
    prod1   = coef.c1 * previous_one;
    prod2   = coef.c2 * previous_two;
    pred    = 25'(prod1) + 25'(prod2) + adbd_pkg::ROUND_BIAS;
    pred_sh = pred >>> 6;
    sum     = scaled + 32'(pred_sh);
    if (sum < adbd_pkg::SAMPLE_MIN) decoded = adbd_pkg::SAMPLE_MIN[15:0];
    else if (sum > adbd_pkg::SAMPLE_MAX) decoded = adbd_pkg::SAMPLE_MAX[15:0];
    else decoded = sum[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_amount <= adbd_pkg::SHIFT_RESET;
      filter_id    <= '0;
      previous_one <= '0;
      previous_two <= '0;
    end else begin
      if (cmd.take_header) begin
        shift_amount <= {1'b1, byte_in[3:0]};
        filter_id    <= byte_in[7:4];
      end
      if (cmd.emit) begin
        previous_one <= decoded;
        previous_two <= previous_one;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_byte) data_byte <= byte_in;
    if (cmd.emit) begin
      sample    <= decoded;
      pair_last <= cmd.phase_hi;
      block_end <= cmd.block_end;
    end
  end

endmodule

@@ rtl/adbd_checker.sv @@
// ----------------------------------------------------------------------------
// ADPCM block decoder checker
// Port-level checks on the output beats, bound to the top level.
// ----------------------------------------------------------------------------
module adbd_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic signed [adbd_pkg::SAMPLE_W-1:0] sample,
  input logic                                 pair_last,
  input logic                                 block_end
);

  logic beat;
  logic expect_hi;

  assign beat = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      expect_hi <= 1'b0;
    end else if (beat) begin
      expect_hi <= !pair_last;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(sample) && $stable(pair_last))
    else $error("stalled output beat changed");

  a_pair_hi: assert property (@(posedge clk) disable iff (rst)
    beat && expect_hi |-> pair_last)
    else $error("low-nibble sample not followed by its high-nibble sample");

  a_pair_lo: assert property (@(posedge clk) disable iff (rst)
    beat && !expect_hi |-> !pair_last)
    else $error("high-nibble sample without a low-nibble sample before it");

  a_end: assert property (@(posedge clk) disable iff (rst)
    beat && block_end |-> pair_last)
    else $error("block end flagged on a low-nibble sample");

endmodule

bind adpcm_block_decoder_unit adbd_checker u_adbd_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .sample    (sample),
  .pair_last (pair_last),
  .block_end (block_end)
);
